// ===== src/vec3_normalize_unit_core_defines.svh =====
// Assertion macros shared by the vector normalization RTL.
`ifndef VEC3_NORMALIZE_UNIT_CORE_DEFINES_SVH
`define VEC3_NORMALIZE_UNIT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define V3N_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define V3N_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define V3N_ASSERT(lbl, prop, msg)
`define V3N_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== src/v3n_pkg.sv =====
// Types and constants of the vector normalization pipeline.
`default_nettype none
package v3n_pkg;
  localparam int unsigned CompW   = 32;
  localparam int unsigned SqrtN   = 32;
  localparam int unsigned DivN    = 31;

  localparam logic REG_SAFE_MODE  = 1'b0;
  localparam logic REG_MIN_LENGTH = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [63:0]      rad;
    logic [33:0]      rem;
    logic [31:0]      root;
  } sqrt_pkt_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       neg;
    logic [31:0]      len;
    logic [31:0]      dvs;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] nbits;
    logic [2:0][30:0] quo;
  } div_pkt_t;
endpackage
`default_nettype wire

// ===== src/v3n_sqrt_cell.sv =====
// One bit of the digit-by-digit integer square root.
`default_nettype none
module v3n_sqrt_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire v3n_pkg::sqrt_pkt_t pkt_i,
  output v3n_pkg::sqrt_pkt_t      pkt_o
);
  v3n_pkg::sqrt_pkt_t pkt_d, pkt_q;
  logic [35:0] trial_rem;
  logic [35:0] trial_sub;

  always_comb begin
    trial_rem = {pkt_i.rem, pkt_i.rad[63:62]};
    trial_sub = {2'b00, pkt_i.root, 2'b01};
    pkt_d = pkt_i;
    pkt_d.rad = {pkt_i.rad[61:0], 2'b00};
    if (trial_rem >= trial_sub) begin
      pkt_d.rem  = 34'(trial_rem - trial_sub);
      pkt_d.root = {pkt_i.root[30:0], 1'b1};
    end else begin
      pkt_d.rem  = trial_rem[33:0];
      pkt_d.root = {pkt_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else if (en_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;
endmodule
`default_nettype wire

// ===== src/v3n_div_cell.sv =====
// One quotient bit of the three restoring dividers.
`default_nettype none
module v3n_div_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire v3n_pkg::div_pkt_t pkt_i,
  output v3n_pkg::div_pkt_t      pkt_o
);
  v3n_pkg::div_pkt_t pkt_d, pkt_q;
  logic [2:0][32:0] part;

  always_comb begin
    pkt_d = pkt_i;
    for (int l = 0; l < 3; l++) begin
      part[l] = {pkt_i.rem[l], pkt_i.nbits[l][30]};
      pkt_d.nbits[l] = {pkt_i.nbits[l][29:0], 1'b0};
      if (part[l] >= {1'b0, pkt_i.dvs}) begin
        pkt_d.rem[l] = 32'(part[l] - {1'b0, pkt_i.dvs});
        pkt_d.quo[l] = {pkt_i.quo[l][29:0], 1'b1};
      end else begin
        pkt_d.rem[l] = part[l][31:0];
        pkt_d.quo[l] = {pkt_i.quo[l][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else if (en_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;
endmodule
`default_nettype wire

// ===== src/vec3_normalize_unit_core.sv =====
// Top level of the pipelined 3D vector normalization unit.
// A request carries x_in_i, y_in_i and z_in_i (signed Q16.16) and is taken when
// valid_i is high and stall_o is low. The result carries norm_x_o, norm_y_o and
// norm_z_o (signed Q2.30), vec_length_o (Q16.16) and zero_length_o, and is taken
// when valid_o is high and stall_i is low.
// The unit accepts one request every cycle while the receiver does not stall.
// In order, registers form magnitudes, squares and their sum, a chain of 32
// square root cells yields one length bit per cycle, a register selects the
// divisor, a chain of 31 divider cells yields one quotient bit per cycle for all
// three components, and a last register applies the signs.
// When the receiver stalls a waiting result, the whole pipeline holds and stall_o
// is raised in the same cycle, so no result is lost.
// Reset empties the pipeline and sets safe_mode to 1 and min_length to 1.
// The registers sit on the APB port at byte addresses 0 and 4. The user must
// write them only while the unit is empty, which the block itself leaves unchecked.
`default_nettype none
`include "vec3_normalize_unit_core_defines.svh"
module vec3_normalize_unit_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] x_in_i,
  input  wire logic [31:0] y_in_i,
  input  wire logic [31:0] z_in_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      norm_x_o,
  output logic [31:0]      norm_y_o,
  output logic [31:0]      norm_z_o,
  output logic [31:0]      vec_length_o,
  output logic             zero_length_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic        safe_q, safe_d;
  logic [15:0] minlen_q, minlen_d;
  logic        en;

  assign pready = 1'b1;
  assign en = !(valid_o && stall_i);
  assign stall_o = valid_o && stall_i;

  always_comb begin
    safe_d   = safe_q;
    minlen_d = minlen_q;
    if (psel && penable && pwrite) begin
      unique case (paddr[2])
        v3n_pkg::REG_SAFE_MODE:  safe_d   = pwdata[0];
        v3n_pkg::REG_MIN_LENGTH: minlen_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      v3n_pkg::REG_SAFE_MODE:  prdata = {31'b0, safe_q};
      v3n_pkg::REG_MIN_LENGTH: prdata = {16'b0, minlen_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_q   <= 1'b1;
      minlen_q <= 16'd1;
    end else begin
      safe_q   <= safe_d;
      minlen_q <= minlen_d;
    end
  end

  // Front stages: magnitudes, squares, sum.
  logic [2:0][31:0] comp;
  logic [2:0][31:0] mag1_d, mag1_q, mag2_q;
  logic [2:0]       neg1_d, neg1_q, neg2_q;
  logic [2:0][63:0] sq2_d, sq2_q;
  logic             v1_q, v2_q;
  v3n_pkg::sqrt_pkt_t sq_pkt [v3n_pkg::SqrtN+1];

  assign comp = {z_in_i, y_in_i, x_in_i};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      neg1_d[l] = comp[l][31];
      mag1_d[l] = comp[l][31] ? 32'(-comp[l]) : comp[l];
      sq2_d[l]  = mag1_q[l] * mag1_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q <= mag1_d;
      neg1_q <= neg1_d;
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      sq2_q  <= sq2_d;
    end
  end

  v3n_pkg::sqrt_pkt_t sq_init_d;

  always_comb begin
    sq_init_d.valid = v2_q;
    sq_init_d.mag   = mag2_q;
    sq_init_d.neg   = neg2_q;
    sq_init_d.rad   = sq2_q[0] + sq2_q[1] + sq2_q[2];
    sq_init_d.rem   = '0;
    sq_init_d.root  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_pkt[0] <= '0;
    end else if (en) begin
      sq_pkt[0] <= sq_init_d;
    end
  end

  for (genvar i = 0; i < v3n_pkg::SqrtN; i++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .pkt_i (sq_pkt[i]),
      .pkt_o (sq_pkt[i+1])
    );
  end

  // Divisor selection and divider chain.
  v3n_pkg::sqrt_pkt_t sq_last;
  v3n_pkg::div_pkt_t  dv_init_d;
  v3n_pkg::div_pkt_t  dv_pkt [v3n_pkg::DivN+1];

  assign sq_last = sq_pkt[v3n_pkg::SqrtN];

  always_comb begin
    dv_init_d.valid = sq_last.valid;
    dv_init_d.neg   = sq_last.neg;
    dv_init_d.len   = sq_last.root;
    if (safe_q && (sq_last.root < {16'b0, minlen_q})) begin
      dv_init_d.dvs = {16'b0, minlen_q};
    end else begin
      dv_init_d.dvs = sq_last.root;
    end
    for (int l = 0; l < 3; l++) begin
      dv_init_d.rem[l]   = {1'b0, sq_last.mag[l][31:1]};
      dv_init_d.nbits[l] = {sq_last.mag[l][0], 30'b0};
      dv_init_d.quo[l]   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_pkt[0] <= '0;
    end else if (en) begin
      dv_pkt[0] <= dv_init_d;
    end
  end

  for (genvar i = 0; i < v3n_pkg::DivN; i++) begin : g_div
    v3n_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .pkt_i (dv_pkt[i]),
      .pkt_o (dv_pkt[i+1])
    );
  end

  // Output register with sign application.
  v3n_pkg::div_pkt_t dv_last;
  logic [2:0][31:0]  norm_d, norm_q;
  logic              out_v_q;
  logic [31:0]       len_q;

  assign dv_last = dv_pkt[v3n_pkg::DivN];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_last.dvs == '0) begin
        norm_d[l] = '0;
      end else if (dv_last.neg[l]) begin
        norm_d[l] = 32'(-{1'b0, dv_last.quo[l]});
      end else begin
        norm_d[l] = {1'b0, dv_last.quo[l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      norm_q <= norm_d;
      len_q  <= dv_last.len;
    end
  end

  assign valid_o       = out_v_q;
  assign norm_x_o      = norm_q[0];
  assign norm_y_o      = norm_q[1];
  assign norm_z_o      = norm_q[2];
  assign vec_length_o  = len_q;
  assign zero_length_o = (len_q == '0);

  `V3N_ASSERT(a_zero_norms, !(valid_o && zero_length_o) || (norm_x_o == 0 && norm_y_o == 0 && norm_z_o == 0), "zero length with nonzero components")
  `V3N_ASSERT(a_norm_range, !valid_o || ($signed(norm_x_o) <= 32'sd1073741824 && $signed(norm_x_o) >= -32'sd1073741824), "x component out of unit range")
  `V3N_ASSERT_NEXT(a_hold_len, valid_o && stall_i, $stable(vec_length_o) && $stable(norm_z_o), "stalled result changed inside pipeline")
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the 3D vector normalization unit.
`default_nettype none
module tb;
  localparam int unsigned Latency = 68;
  localparam int unsigned MaxIdle = 20000;

  typedef struct {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic [31:0] len;
    logic        zero;
  } norm_vec_t;

  class norm_scoreboard;
    norm_vec_t   pending_q[$];
    bit          safe_mode = 1'b1;
    logic [15:0] min_length = 16'd1;
    int          mismatches = 0;

    function logic [31:0] isqrt(logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] b;
      rem = v;
      res = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= res + b) begin
          rem = rem - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res[31:0];
    endfunction

    function logic [31:0] scale(logic [31:0] c, logic [31:0] dvs);
      logic [63:0] mag;
      logic [63:0] q;
      mag = c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
      if (dvs == 0) return 32'd0;
      q = (mag << 30) / dvs;
      if (c[31]) q = -q;
      return q[31:0];
    endfunction

    function void note_request(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [63:0] mx, my, mz, sq;
      logic [31:0] len, dvs;
      norm_vec_t   e;
      mx = x[31] ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
      my = y[31] ? (64'h1_0000_0000 - {32'd0, y}) : {32'd0, y};
      mz = z[31] ? (64'h1_0000_0000 - {32'd0, z}) : {32'd0, z};
      sq = mx * mx + my * my + mz * mz;
      len = isqrt(sq);
      dvs = len;
      if (safe_mode && dvs < {16'd0, min_length}) dvs = {16'd0, min_length};
      e.nx = scale(x, dvs);
      e.ny = scale(y, dvs);
      e.nz = scale(z, dvs);
      e.len = len;
      e.zero = (len == 0);
      pending_q.push_back(e);
    endfunction

    function void check_result(norm_vec_t a);
      norm_vec_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result len=%h", a.len);
        return;
      end
      e = pending_q.pop_front();
      if (a.nx !== e.nx || a.ny !== e.ny || a.nz !== e.nz || a.len !== e.len ||
          a.zero !== e.zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %h %h %h len %h z %b, got %h %h %h len %h z %b",
                   e.nx, e.ny, e.nz, e.len, e.zero, a.nx, a.ny, a.nz, a.len, a.zero);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic [31:0] x_in_i = '0, y_in_i = '0, z_in_i = '0;
  logic stall_o, valid_o, zero_length_o, pready;
  logic [31:0] norm_x_o, norm_y_o, norm_z_o, vec_length_o, prdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;

  norm_scoreboard sb = new();
  bit rx_idle_on = 1'b1;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  vec3_normalize_unit_core u_top (.*);

  always @(posedge clk_i) begin
    norm_vec_t r;
    if (rst_ni && valid_i && !stall_o) sb.note_request(x_in_i, y_in_i, z_in_i);
    if (rst_ni && valid_o && !stall_i) begin
      r.nx = norm_x_o;
      r.ny = norm_y_o;
      r.nz = norm_z_o;
      r.len = vec_length_o;
      r.zero = zero_length_o;
      sb.check_result(r);
    end
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > MaxIdle) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        stall_i <= 1'b1;
        repeat (150) @(posedge clk_i);
        long_hold = 1'b0;
        stall_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'd0) sb.safe_mode = data[0];
    else if (addr == 3'd4) sb.min_length = data[15:0];
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 4);
      valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    x_in_i <= x;
    y_in_i <= y;
    z_in_i <= z;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 255) - 128;
      2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      3: return {{4{$urandom_range(0, 1) == 1}}, 28'($urandom())};
      4: return 32'h8000_0000;
      default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
    endcase
  endfunction

  task automatic random_phase(int count, bit gaps);
    for (int i = 0; i < count; i++) begin
      if (long_hold == 1'b0 && i == count / 2 && gaps) long_hold = 1'b1;
      send(rand_comp(), rand_comp(), rand_comp(), gaps);
    end
    valid_i <= 1'b0;
    @(posedge clk_i);
    drain();
  endtask

  initial begin
    logic [31:0] ext[6];
    ext = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 6; i++) send(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6], 1'b1);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send(32'h0, 32'h0, 32'h0, 1'b0);
    send(32'h0, 32'h0, 32'h1, 1'b0);
    valid_i <= 1'b0;
    @(posedge clk_i);
    drain();
    apb_write(3'd0, 32'd0);
    send(32'h0, 32'h0, 32'h0, 1'b0);
    send(32'h3, 32'hFFFF_FFFD, 32'h0, 1'b0);
    valid_i <= 1'b0;
    @(posedge clk_i);
    drain();
    apb_write(3'd0, 32'd1);
    apb_write(3'd4, 32'hFFFF);
    send(32'h0, 32'h0, 32'h0, 1'b0);
    send(32'h0001_0000, 32'hFFFF_0000, 32'h100, 1'b0);
    random_phase(300, 1'b1);
    apb_write(3'd4, 32'd0);
    send(32'h0, 32'h0, 32'h0, 1'b0);
    random_phase(300, 1'b1);
    apb_write(3'd0, 32'd0);
    apb_write(3'd4, 32'($urandom_range(0, 65535)));
    random_phase(300, 1'b1);
    apb_write(3'd0, 32'd1);
    apb_write(3'd4, 32'($urandom_range(0, 65535)));
    rx_idle_on = 1'b0;
    random_phase(330, 1'b0);
    if (sb.mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
